### hw/rtl/efc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_pkg: shared types and constants of the envelope frame checker
// Item structs, status and register codes, header constants and the CRC-32
// byte update.
// ----------------------------------------------------------------------------
package efc_pkg;

	// Frame layout
	localparam int unsigned HeaderBytes  = 7;
	localparam int unsigned TrailerBytes = 4;
	localparam int unsigned PayloadMax   = 1024;
	localparam int unsigned FrameCap     = 4084;
	localparam int unsigned LengthCap    = (PayloadMax < FrameCap) ? PayloadMax : FrameCap;

	// "MFP1", entry 0 is the first byte on the wire
	localparam logic [3:0][7:0] Magic = {8'h31, 8'h50, 8'h46, 8'h4D};

	localparam logic [31:0] CrcPoly = 32'hEDB88320;
	localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

	// Queue between classifier and CRC stage
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_MAGIC  = 3'd1,
		ST_BAD_VER    = 3'd2,
		ST_BAD_LEN    = 3'd3,
		ST_SIZE       = 3'd4,
		ST_CRC        = 3'd5
	} status_t;

	typedef enum logic {
		CFG_VERSION     = 1'b0,
		CFG_MAX_PAYLOAD = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_payload;
		logic       frame_done;
		status_t    status;
	} out_item_t;

	// Classified byte as handed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_payload;
		logic       crc_en;     // byte enters the running CRC
		logic       rx_en;      // byte is part of the trailer
		status_t    pre_status; // header/size verdict, valid with last
	} cls_item_t;

	// Reflected CRC-32, one byte, unrolled
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

### hw/rtl/efc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efc_front: byte classifier
// Tracks the offset in the frame, checks magic, version and length field,
// and tags each byte for the CRC stage.
// ----------------------------------------------------------------------------
module efc_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 src_valid,
	output logic                      src_ready,
	input  wire efc_pkg::in_item_t    src_req,
	input  wire logic [7:0]           exp_version,
	input  wire logic [10:0]          max_payload,
	input  wire logic                 q_full,
	output logic                      push,
	output efc_pkg::cls_item_t        cls
);

	localparam logic [11:0] LimCap = 12'(efc_pkg::LengthCap);

	logic [11:0]       pos_q;
	logic [15:0]       len_q;
	efc_pkg::status_t  err_q;

	logic [15:0]       len_nx;
	efc_pkg::status_t  err_nx;
	logic [11:0]       lim;
	logic              len_ok;
	logic [16:0]       pos_x;
	logic [16:0]       pay_end;
	logic [16:0]       trl_end;
	logic              in_hdr;
	logic              size_bad;

	assign src_ready = !q_full;
	assign push      = src_valid && src_ready;

	always_comb begin
		lim     = ({1'b0, max_payload} > LimCap) ? LimCap : {1'b0, max_payload};
		len_ok  = (len_q != 16'd0) && (len_q <= {4'h0, lim});
		pos_x   = {5'h0, pos_q};
		pay_end = {1'b0, len_q} + 17'(efc_pkg::HeaderBytes);
		trl_end = pay_end + 17'(efc_pkg::TrailerBytes);
		in_hdr  = pos_q < 12'(efc_pkg::HeaderBytes);
		len_nx  = len_q;
		err_nx  = err_q;

		if (pos_q < 12'd4) begin
			if (src_req.in_byte != efc_pkg::Magic[pos_q[1:0]] && err_q == efc_pkg::ST_OK) begin
				err_nx = efc_pkg::ST_BAD_MAGIC;
			end
		end else if (pos_q == 12'd4) begin
			if (src_req.in_byte != exp_version && err_q == efc_pkg::ST_OK) begin
				err_nx = efc_pkg::ST_BAD_VER;
			end
		end else if (pos_q == 12'd5) begin
			len_nx = {src_req.in_byte, 8'h00};
		end else if (pos_q == 12'd6) begin
			len_nx = {len_q[15:8], src_req.in_byte};
			if ((len_nx == 16'd0 || len_nx > {4'h0, lim}) && err_q == efc_pkg::ST_OK) begin
				err_nx = efc_pkg::ST_BAD_LEN;
			end
		end

		// total must be header + payload + trailer; offset of last = total - 1
		size_bad = in_hdr ||
			(pos_x != {1'b0, len_nx} + 17'(efc_pkg::HeaderBytes + efc_pkg::TrailerBytes - 1));

		cls.data       = src_req.in_byte;
		cls.last       = src_req.last_byte;
		cls.is_payload = !in_hdr && len_ok && (pos_x < pay_end);
		cls.crc_en     = in_hdr || cls.is_payload;
		cls.rx_en      = !in_hdr && len_ok && (pos_x >= pay_end) && (pos_x < trl_end);
		if (err_nx != efc_pkg::ST_OK) begin
			cls.pre_status = err_nx;
		end else if (size_bad) begin
			cls.pre_status = efc_pkg::ST_SIZE;
		end else begin
			cls.pre_status = efc_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			len_q <= '0;
			err_q <= efc_pkg::ST_OK;
		end else if (push) begin
			if (src_req.last_byte) begin
				pos_q <= '0;
				len_q <= '0;
				err_q <= efc_pkg::ST_OK;
			end else begin
				if (pos_q != 12'hFFF) begin
					pos_q <= pos_q + 12'd1;
				end
				len_q <= len_nx;
				err_q <= err_nx;
			end
		end
	end

	// frame state is clean after an end of frame
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		push && src_req.last_byte |=> pos_q == 12'd0 && err_q == efc_pkg::ST_OK)
		else $error("front state not cleared after last byte");

	// nothing in the header region is ever tagged as payload or trailer
	a_hdr_tags: assert property (@(posedge clk) disable iff (!arst_n)
		push && pos_q < 12'(efc_pkg::HeaderBytes) |-> !cls.is_payload && !cls.rx_en)
		else $error("header byte tagged as payload or trailer");

endmodule
`default_nettype wire

### hw/rtl/efc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efc_queue: short FIFO of classified bytes
// Decouples the classifier from the CRC stage.
// ----------------------------------------------------------------------------
module efc_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire efc_pkg::cls_item_t wr_item,
	output logic                    full,
	input  wire logic               pop,
	output logic                    rd_valid,
	output efc_pkg::cls_item_t      rd_item
);

	localparam int unsigned Depth = efc_pkg::QueueDepth;
	localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW  = $clog2(Depth + 1);

	efc_pkg::cls_item_t ent_q [Depth];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CntW-1:0]    cnt_q;

	assign full     = (cnt_q == CntW'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !rd_valid))
		else $error("queue overrun or underrun");

endmodule
`default_nettype wire

### hw/rtl/efc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efc_back: CRC stage and result register
// Runs the CRC-32, collects the trailer and issues one result per byte.
// ----------------------------------------------------------------------------
module efc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rd_valid,
	input  wire efc_pkg::cls_item_t rd_item,
	output logic                    pop,
	output logic                    dst_valid,
	input  wire logic               dst_ready,
	output efc_pkg::out_item_t      dst_req
);

	logic [31:0]        crc_q;
	logic [31:0]        rx_q;
	logic               dst_valid_q;
	efc_pkg::out_item_t dst_req_q;

	logic [31:0]        crc_nx;
	logic [31:0]        rx_nx;
	efc_pkg::out_item_t res;

	assign pop       = rd_valid && (!dst_valid_q || dst_ready);
	assign dst_valid = dst_valid_q;
	assign dst_req   = dst_req_q;

	always_comb begin
		crc_nx = rd_item.crc_en ? efc_pkg::crc_byte(crc_q, rd_item.data) : crc_q;
		rx_nx  = rd_item.rx_en ? {rx_q[23:0], rd_item.data} : rx_q;
		res.out_byte   = rd_item.data;
		res.is_payload = rd_item.is_payload;
		res.frame_done = rd_item.last;
		res.status     = efc_pkg::ST_OK;
		if (rd_item.last) begin
			if (rd_item.pre_status != efc_pkg::ST_OK) begin
				res.status = rd_item.pre_status;
			end else if ((crc_nx ^ efc_pkg::CrcInit) != rx_nx) begin
				res.status = efc_pkg::ST_CRC;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dst_req_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= efc_pkg::CrcInit;
			rx_q        <= '0;
			dst_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				dst_valid_q <= 1'b1;
				if (rd_item.last) begin
					crc_q <= efc_pkg::CrcInit;
					rx_q  <= '0;
				end else begin
					crc_q <= crc_nx;
					rx_q  <= rx_nx;
				end
			end else if (dst_ready) begin
				dst_valid_q <= 1'b0;
			end
		end
	end

	a_crc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop && rd_item.last |=> crc_q == efc_pkg::CrcInit && rx_q == 32'd0)
		else $error("CRC state not restarted after frame end");

	a_status_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid_q && !dst_req_q.frame_done |-> dst_req_q.status == efc_pkg::ST_OK)
		else $error("status set on a byte that does not end a frame");

endmodule
`default_nettype wire

### hw/rtl/envelope_frame_checker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// envelope_frame_checker_unit: byte-stream envelope checker
// Checks magic "MFP1", version, length field, total size and a trailing
// big-endian CRC-32 per frame; passes every byte through, tags payload.
// ----------------------------------------------------------------------------
//
//  channel  signals                        direction  carries
//  -------  -----------------------------  ---------  --------------------------
//  src      src_valid src_ready src_req    in         one envelope byte + last
//  dst      dst_valid dst_ready dst_req    out        byte, payload tag, status
//  cfg      cfg_valid cfg_ready cfg_index  in         register writes
//           cfg_data                                  (0 version, 1 max payload)
//
// One byte per cycle sustained while dst keeps up. The front classifies a byte
// in the cycle it is accepted; it passes a two-entry queue and the byte-wide
// CRC-32 stage into the result register, which drives dst.
// Reset clears frame counters, error state and CRC and loads the register
// defaults (version 1, max payload 1024); no clearing pass.
// A dst stall fills the queue and then drops src_ready; cfg_ready stays high.
// ----------------------------------------------------------------------------
module envelope_frame_checker_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               src_valid,
	output logic                    src_ready,
	input  wire efc_pkg::in_item_t  src_req,
	output logic                    dst_valid,
	input  wire logic               dst_ready,
	output efc_pkg::out_item_t      dst_req,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [10:0]        cfg_data
);

	// configuration registers
	logic [7:0]  exp_version_q;
	logic [10:0] max_payload_q;

	// front -> queue -> back
	logic               push;
	logic               q_full;
	logic               pop;
	logic               rd_valid;
	efc_pkg::cls_item_t cls;
	efc_pkg::cls_item_t rd_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_version_q <= 8'd1;
			max_payload_q <= 11'd1024;
		end else if (cfg_valid && cfg_ready) begin
			case (efc_pkg::cfg_reg_t'(cfg_index))
				efc_pkg::CFG_VERSION:     exp_version_q <= cfg_data[7:0];
				efc_pkg::CFG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				default:                  ;
			endcase
		end
	end

	// front: offset tracking, header checks, tagging
	efc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_ready   (src_ready),
		.src_req     (src_req),
		.exp_version (exp_version_q),
		.max_payload (max_payload_q),
		.q_full      (q_full),
		.push        (push),
		.cls         (cls)
	);

	// decoupling queue
	efc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (cls),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (rd_valid),
		.rd_item  (rd_item)
	);

	// back: CRC, trailer compare, result register
	efc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_valid  (rd_valid),
		.rd_item   (rd_item),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_req   (dst_req)
	);

endmodule
`default_nettype wire

### verif/efc_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efc_stream_checker: result checker for the envelope frame checker
// Watches the src, dst and cfg channels, runs its own byte-level model of the
// frame check and compares every dst request with the oldest prediction.
// ----------------------------------------------------------------------------
module efc_stream_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	input  logic               src_ready,
	input  efc_pkg::in_item_t  src_req,
	input  logic               dst_valid,
	input  logic               dst_ready,
	input  efc_pkg::out_item_t dst_req,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [10:0]        cfg_data,
	output int                 mismatches,
	output int                 pending,
	output int                 frames_seen,
	output int                 frames_clean
);

	logic [7:0]         want_version;
	logic [10:0]        len_max_reg;
	logic [11:0]        pos;
	logic [31:0]        crc_acc;
	logic [15:0]        len_field;
	logic [31:0]        trailer;
	efc_pkg::status_t   first_err;
	efc_pkg::out_item_t tagged_bytes_q[$];
	int                 bad_results;
	int                 done_count;
	int                 clean_count;

	// bit-serial reflected CRC-32
	function automatic logic [31:0] crc32_next(input logic [31:0] acc, input logic [7:0] data);
		logic [31:0] r;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			if (r[0] ^ data[i])
				r = (r >> 1) ^ efc_pkg::CrcPoly;
			else
				r = r >> 1;
		end
		return r;
	endfunction

	function automatic void note_error(input efc_pkg::status_t code);
		if (first_err == efc_pkg::ST_OK)
			first_err = code;
	endfunction

	function automatic void clear_frame();
		pos       = '0;
		crc_acc   = efc_pkg::CrcInit;
		len_field = '0;
		trailer   = '0;
		first_err = efc_pkg::ST_OK;
	endfunction

	// expected dst request for one accepted byte; advances the frame state
	function automatic efc_pkg::out_item_t classify_byte(input efc_pkg::in_item_t req);
		efc_pkg::out_item_t res;
		int unsigned        p;
		int unsigned        len;
		int unsigned        lim;
		logic               len_ok;
		p   = pos;
		len = len_field;
		lim = (len_max_reg < efc_pkg::LengthCap) ? len_max_reg : efc_pkg::LengthCap;
		len_ok = (len != 0) && (len <= lim);
		res.out_byte   = req.in_byte;
		res.is_payload = 1'b0;
		res.frame_done = 1'b0;
		res.status     = efc_pkg::ST_OK;

		if (p < 4) begin
			if (req.in_byte != efc_pkg::Magic[p])
				note_error(efc_pkg::ST_BAD_MAGIC);
		end else if (p == 4) begin
			if (req.in_byte != want_version)
				note_error(efc_pkg::ST_BAD_VER);
		end else if (p == 5) begin
			len_field = {req.in_byte, 8'h00};
		end else if (p == 6) begin
			len_field = {len_field[15:8], req.in_byte};
			if (len_field == 0 || len_field > lim)
				note_error(efc_pkg::ST_BAD_LEN);
		end

		if (p < efc_pkg::HeaderBytes) begin
			crc_acc = crc32_next(crc_acc, req.in_byte);
		end else if (len_ok) begin
			if (p < efc_pkg::HeaderBytes + len) begin
				crc_acc = crc32_next(crc_acc, req.in_byte);
				res.is_payload = 1'b1;
			end else if (p < efc_pkg::HeaderBytes + len + efc_pkg::TrailerBytes) begin
				trailer = {trailer[23:0], req.in_byte};
			end
		end

		if (pos != 12'hFFF)
			pos = pos + 12'd1;

		if (req.last_byte) begin
			res.frame_done = 1'b1;
			res.status = first_err;
			if (first_err == efc_pkg::ST_OK) begin
				if (p < efc_pkg::HeaderBytes ||
				    p != efc_pkg::HeaderBytes + len_field + efc_pkg::TrailerBytes - 1)
					res.status = efc_pkg::ST_SIZE;
				else if ((crc_acc ^ efc_pkg::CrcInit) != trailer)
					res.status = efc_pkg::ST_CRC;
			end
			done_count++;
			if (res.status == efc_pkg::ST_OK)
				clean_count++;
			clear_frame();
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		efc_pkg::out_item_t want;
		if (!arst_n) begin
			want_version = 8'd1;
			len_max_reg  = 11'd1024;
			clear_frame();
			tagged_bytes_q.delete();
		end else begin
			// dst first: a result leaving now never belongs to a byte entering now
			if (dst_valid && dst_ready) begin
				if (tagged_bytes_q.size() == 0) begin
					if (bad_results < 10)
						$display("%0t: unexpected result byte %02h payload %0b done %0b status %0d",
							$realtime, dst_req.out_byte, dst_req.is_payload,
							dst_req.frame_done, dst_req.status);
					bad_results++;
				end else begin
					want = tagged_bytes_q.pop_front();
					if (dst_req.out_byte !== want.out_byte ||
					    dst_req.is_payload !== want.is_payload ||
					    dst_req.frame_done !== want.frame_done ||
					    dst_req.status !== want.status) begin
						if (bad_results < 10)
							$display({"%0t: mismatch expected byte %02h payload %0b done %0b ",
								"status %0d, got byte %02h payload %0b done %0b status %0d"},
								$realtime, want.out_byte, want.is_payload, want.frame_done,
								want.status, dst_req.out_byte, dst_req.is_payload,
								dst_req.frame_done, dst_req.status);
						bad_results++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == efc_pkg::CFG_VERSION)
					want_version = cfg_data[7:0];
				else
					len_max_reg = cfg_data;
			end
			if (src_valid && src_ready)
				tagged_bytes_q.push_back(classify_byte(src_req));
		end
		pending      <= tagged_bytes_q.size();
		mismatches   <= bad_results;
		frames_seen  <= done_count;
		frames_clean <= clean_count;
	end

endmodule

### verif/envelope_frame_checker_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// envelope_frame_checker_unit_test: stimulus and verdict for the frame checker
// Sends directed and random envelopes (good frames, each error kind, short,
// noisy and overlong frames) under six register settings and three idling
// mixes; efc_stream_checker predicts and compares every result request.
// ----------------------------------------------------------------------------
module envelope_frame_checker_unit_test;

	localparam int ItemTarget    = 1750;
	localparam int SettingCount  = 6;
	localparam int WatchdogLimit = 4000;  // cycles with no request moving on any channel
	localparam int HoldCycles    = 64;    // long dst back-pressure stretch
	localparam int SettleCycles  = 4;     // idle wait after the last predicted result
	localparam int DrainCycles   = 8;
	localparam int OverlongBytes = 4100;  // past the 12-bit position counter

	// every block input has a known value from time zero
	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               src_valid = 1'b0;
	logic               src_ready;
	efc_pkg::in_item_t  src_req   = '0;
	logic               dst_valid;
	logic               dst_ready = 1'b0;
	efc_pkg::out_item_t dst_req;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_index = 1'b0;
	logic [10:0]        cfg_data  = '0;

	int mismatches;
	int pending;
	int frames_seen;
	int frames_clean;

	// idling controls; dst side values are read by the receiver process
	int src_idle_pct = 0;
	int dst_idle_pct = 0;
	int hold_asks    = 0;
	int hold_seen    = 0;
	int hold_left    = 0;
	int stall_count  = 0;
	int bytes_sent   = 0;

	// envelope being built, sent first byte first
	logic [7:0]  frame_bytes[$];
	logic [7:0]  cur_version = 8'd1;
	logic [10:0] cur_max     = 11'd1024;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	envelope_frame_checker_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_req   (src_req),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_req   (dst_req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	efc_stream_checker u_stream_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_ready    (src_ready),
		.src_req      (src_req),
		.dst_valid    (dst_valid),
		.dst_ready    (dst_ready),
		.dst_req      (dst_req),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending),
		.frames_seen  (frames_seen),
		.frames_clean (frames_clean)
	);

	// Receiver: random ready, or a long hold counted here once the stimulus
	// asks for one. The sender keeps offering during a hold, so the queue
	// inside the block fills and src_ready has to drop.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_ready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_left <= HoldCycles;
			dst_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			dst_ready <= 1'b0;
		end else begin
			dst_ready <= ($urandom_range(99) >= dst_idle_pct);
		end
	end

	// Watchdog: a run that stops moving requests is a failure
	always @(posedge clk) begin
		if (arst_n) begin
			if ((src_valid && src_ready) || (dst_valid && dst_ready) || (cfg_valid && cfg_ready))
				stall_count <= 0;
			else
				stall_count <= stall_count + 1;
			if (stall_count >= WatchdogLimit) begin
				$display("watchdog: no request moved for %0d cycles", WatchdogLimit);
				$display("FAIL envelope_frame_checker_unit");
				$finish;
			end
		end
	end

	// byte-wise reflected CRC-32 for building trailers
	function automatic logic [31:0] crc_feed(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] r;
		r = acc ^ {24'h0, b};
		repeat (8)
			r = r[0] ? ((r >> 1) ^ efc_pkg::CrcPoly) : (r >> 1);
		return r;
	endfunction

	// accepted length range is 1 .. min(max_payload, LengthCap)
	function automatic int unsigned len_limit();
		return (cur_max < efc_pkg::LengthCap) ? cur_max : efc_pkg::LengthCap;
	endfunction

	// Header with the given length field, body_n random payload bytes, then a
	// correct trailer over everything before it.
	task automatic build_frame(input logic [15:0] hdr_len, input int body_n, input logic [7:0] ver);
		logic [31:0] acc;
		frame_bytes.delete();
		for (int i = 0; i < 4; i++)
			frame_bytes.push_back(efc_pkg::Magic[i]);
		frame_bytes.push_back(ver);
		frame_bytes.push_back(hdr_len[15:8]);
		frame_bytes.push_back(hdr_len[7:0]);
		for (int i = 0; i < body_n; i++)
			frame_bytes.push_back(8'($urandom));
		acc = efc_pkg::CrcInit;
		foreach (frame_bytes[i])
			acc = crc_feed(acc, frame_bytes[i]);
		acc = acc ^ efc_pkg::CrcInit;
		frame_bytes.push_back(acc[31:24]);
		frame_bytes.push_back(acc[23:16]);
		frame_bytes.push_back(acc[15:8]);
		frame_bytes.push_back(acc[7:0]);
	endtask

	// One src request; random gaps before it per src_idle_pct
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_req   <= '{in_byte: b, last_byte: last};
		do @(posedge clk); while (!src_ready);
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	// sender pauses until every predicted result has come out
	task automatic wait_drained();
		src_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input efc_pkg::cfg_reg_t idx, input logic [10:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// registers change only with the block idle
	task automatic apply_setting(input logic [7:0] ver, input logic [10:0] max_len);
		wait_drained();
		write_reg(efc_pkg::CFG_VERSION, {3'b000, ver});
		write_reg(efc_pkg::CFG_MAX_PAYLOAD, max_len);
		cfg_valid   <= 1'b0;
		cur_version  = ver;
		cur_max      = max_len;
	endtask

	// Mostly well-formed frames with random content, the rest broken or noise
	task automatic make_random_frame();
		int unsigned lim;
		int          kind;
		int          n;
		int          idx;
		lim  = len_limit();
		kind = $urandom_range(99);
		if (lim == 0)
			n = $urandom_range(1, 16);
		else if ($urandom_range(99) == 0)
			n = lim;
		else if ($urandom_range(99) < 3)
			n = $urandom_range(1, lim);
		else
			n = $urandom_range(1, (lim < 24) ? lim : 24);
		build_frame(16'(n), n, cur_version);
		if (kind < 55) begin
			// well-formed
		end else if (kind < 65) begin
			// corrupt a payload or trailer byte: CRC mismatch
			idx = $urandom_range(efc_pkg::HeaderBytes, frame_bytes.size() - 1);
			frame_bytes[idx] ^= 8'(1 << $urandom_range(7));
		end else if (kind < 70) begin
			idx = $urandom_range(3);
			frame_bytes[idx] ^= 8'($urandom_range(1, 255));
		end else if (kind < 75) begin
			frame_bytes[4] ^= 8'($urandom_range(1, 255));
		end else if (kind < 82) begin
			// length field zero or above the limit, short random body
			if ($urandom_range(3) == 0 || lim >= 65535)
				build_frame(16'd0, $urandom_range(0, 12), cur_version);
			else
				build_frame(16'($urandom_range(lim + 1, 65535)), $urandom_range(0, 12),
					cur_version);
		end else if (kind < 90) begin
			// total size off by a few bytes
			n = $urandom_range(1, 3);
			if ($urandom_range(1)) begin
				repeat (n) void'(frame_bytes.pop_back());
			end else begin
				repeat (n) frame_bytes.push_back(8'($urandom));
			end
		end else if (kind < 95) begin
			// ends inside the header
			n = $urandom_range(1, 6);
			while (frame_bytes.size() > n)
				void'(frame_bytes.pop_back());
		end else begin
			frame_bytes.delete();
			repeat ($urandom_range(1, 20)) frame_bytes.push_back(8'($urandom));
		end
	endtask

	initial begin : stimulus
		logic [7:0]  set_ver[SettingCount];
		logic [10:0] set_max[SettingCount];
		int          start;

		// settings: defaults, both extremes, zero max (rejects every length),
		// a random pair, and defaults again
		set_ver = '{8'h01, 8'h00, 8'hFF, 8'h5A, 8'($urandom), 8'h01};
		set_max = '{11'd1024, 11'd1, 11'd2047, 11'd0, 11'($urandom_range(2, 64)), 11'd1024};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset register values
		build_frame(16'd1, 1, 8'h01);              // smallest good frame
		send_frame();
		frame_bytes = '{efc_pkg::Magic[0]};         // last byte at offset zero
		send_frame();
		frame_bytes = '{8'hFF};                     // bad first magic byte
		send_frame();
		frame_bytes = '{efc_pkg::Magic[0], efc_pkg::Magic[1], efc_pkg::Magic[2],
			efc_pkg::Magic[3], 8'h00};              // wrong version
		send_frame();
		frame_bytes = '{efc_pkg::Magic[0], efc_pkg::Magic[1], efc_pkg::Magic[2],
			efc_pkg::Magic[3], 8'h01, 8'h00, 8'h00};
		send_frame();                               // zero length field

		for (int s = 0; s < SettingCount; s++) begin
			apply_setting(set_ver[s], set_max[s]);
			// idling mix: src light/dst heavy, then swapped, then none
			case (s / 2)
				0: begin
					src_idle_pct  = 20;
					dst_idle_pct <= 59;
				end
				1: begin
					src_idle_pct  = 59;
					dst_idle_pct <= 20;
				end
				default: begin
					src_idle_pct  = 0;
					dst_idle_pct <= 0;
				end
			endcase
			// long output holds while the sender keeps going
			if (s == 2 || s == 4)
				hold_asks <= hold_asks + 1;
			// counter saturation: good header, then far too many bytes
			if (s == SettingCount - 1) begin
				build_frame(16'(len_limit()), len_limit(), cur_version);
				while (frame_bytes.size() < OverlongBytes)
					frame_bytes.push_back(8'($urandom));
				send_frame();
			end
			start = bytes_sent;
			while (bytes_sent - start < ItemTarget / SettingCount) begin
				make_random_frame();
				send_frame();
				// one mid-phase pause until the block is empty
				if (s == 4 && bytes_sent - start >= ItemTarget / (2 * SettingCount) &&
				    bytes_sent - start - frame_bytes.size() < ItemTarget / (2 * SettingCount))
					wait_drained();
			end
		end

		// drain: nothing expected, then a few more cycles for stray results
		src_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("covered %0d bytes in %0d frames (%0d clean), six register settings,",
			bytes_sent, frames_seen, frames_clean);
		$display("three idling mixes, two long output holds and one overlong frame");
		if (mismatches == 0 && pending == 0)
			$display("PASS envelope_frame_checker_unit");
		else
			$display("FAIL envelope_frame_checker_unit");
		$finish;
	end

endmodule
